[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// The property must hold at every rising edge out of reset.
`define MEX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// The condition must never be true at a rising edge out of reset.
`define MEX_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define MEX_ASSERT(lbl, prop, msg)
`define MEX_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

[rtl/core/mex_pkg.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Word width, shared types and constants of the exponentiation core.
// ----------------------------------------------------------------------------
package mex_pkg;

	// Datapath width of every residue.
	localparam int WORD_BITS = 32;
	// Width of a counter that walks the bits of one word.
	localparam int CNT_BITS = $clog2(WORD_BITS);

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [CNT_BITS-1:0] cnt_t;

	// Count value of the most significant bit of a word.
	localparam cnt_t LAST_BIT = cnt_t'(WORD_BITS - 1);
	// Residue one, the start value of every power.
	localparam word_t ONE_WORD = word_t'(1);
	// Modulus reset value.
	localparam word_t MODULUS_RESET = word_t'(2);

	// Request to the modular multiplier.
	typedef struct packed {
		logic  start;
		word_t multiplicand;
		word_t multiplier;
	} mm_req_t;

	// Status of the modular multiplier.
	typedef struct packed {
		logic busy;
		logic done;
	} mm_stat_t;

endpackage

[rtl/core/mex_modmul.sv]
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Forms multiplicand * multiplier mod modulus by double-and-add, one
// multiplier bit per cycle from the top bit down.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mex_modmul (
	input  logic             clk,
	input  logic             arst_n,
	input  mex_pkg::mm_req_t req,
	input  mex_pkg::word_t   modulus,
	output mex_pkg::mm_stat_t stat,
	output mex_pkg::word_t   product
);

	mex_pkg::word_t acc_q;
	mex_pkg::word_t mcand_q;
	mex_pkg::word_t mplier_q;
	mex_pkg::cnt_t  cnt_q;
	logic           busy_q;
	logic           done_q;

	logic [mex_pkg::WORD_BITS+1:0] sum;
	logic [mex_pkg::WORD_BITS+1:0] n_ext;
	logic [mex_pkg::WORD_BITS+1:0] n2_ext;
	logic [mex_pkg::WORD_BITS+1:0] diff1;
	logic [mex_pkg::WORD_BITS+1:0] diff2;
	mex_pkg::word_t                acc_next;

	// One step: 2*acc + bit*a is below three times the modulus, so at most
	// two subtractions of the modulus bring it back into range.
	always_comb begin
		n_ext  = {2'b00, modulus};
		n2_ext = {1'b0, modulus, 1'b0};
		sum    = {1'b0, acc_q, 1'b0} +
		         (mplier_q[mex_pkg::WORD_BITS-1] ? {2'b00, mcand_q} : '0);
		diff1  = sum - n_ext;
		diff2  = sum - n2_ext;
		if (sum >= n2_ext) begin
			acc_next = diff2[mex_pkg::WORD_BITS-1:0];
		end else if (sum >= n_ext) begin
			acc_next = diff1[mex_pkg::WORD_BITS-1:0];
		end else begin
			acc_next = sum[mex_pkg::WORD_BITS-1:0];
		end
	end

	// Control: bit counter, busy and done flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= mex_pkg::LAST_BIT;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath: accumulator and the multiplier shift register.
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q    <= '0;
			mcand_q  <= req.multiplicand;
			mplier_q <= req.multiplier;
		end else if (busy_q) begin
			acc_q    <= acc_next;
			mplier_q <= {mplier_q[mex_pkg::WORD_BITS-2:0], 1'b0};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign product   = acc_q;

	`MEX_ASSERT(a_done_pulse, done_q |=> !done_q || $past(req.start) == 1'b0 && !done_q, "done held for more than one cycle")
	`MEX_ASSERT(a_done_after_busy, $fell(busy_q) && !$past(req.start) |-> done_q, "busy ended without done")
	`MEX_ASSERT_NEVER(a_busy_and_done, busy_q && done_q, "busy and done at once")

endmodule

[rtl/core/modular_exponentiation_core.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation core
// Computes base_value ^ exponent mod modulus by left-to-right square and
// multiply over a shared bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// Work: one base reduction, 32 squarings and one multiply per set exponent
//   bit, each a modular product on the shared multiplier.
// Requests: one at a time; the next is taken once the result is registered.
//   A modulus below two answers zero without using the multiplier.
// Reset: arst_n clears control state and sets the modulus to two.

`include "assert_macros.svh"

module modular_exponentiation_core (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel: modulus.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	// Request stream. tdata: base_value [31:0], exponent [63:32].
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,
	// Result stream. tdata: power_result [31:0].
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SQUARE,
		ST_MULT,
		ST_FINISH
	} state_t;

	state_t            state_q;
	mex_pkg::word_t    modulus_q;
	mex_pkg::word_t    base_q;
	mex_pkg::word_t    exp_q;
	mex_pkg::word_t    res_q;
	mex_pkg::cnt_t     cnt_q;
	logic              m_tvalid_q;
	mex_pkg::word_t    m_tdata_q;

	mex_pkg::mm_req_t  mm_req;
	mex_pkg::mm_stat_t mm_stat;
	mex_pkg::word_t    mm_product;
	logic              s_accept;
	logic              small_mod;
	logic              last_bit;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign s_accept  = s_tvalid && s_tready;
	assign small_mod = (modulus_q < mex_pkg::MODULUS_RESET);
	assign last_bit  = (cnt_q == '0);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// Multiplier requests. Reducing the base is the product 1 * base.
	always_comb begin
		mm_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				mm_req.start        = s_accept && !small_mod;
				mm_req.multiplicand = mex_pkg::ONE_WORD;
				mm_req.multiplier   = s_tdata[mex_pkg::WORD_BITS-1:0];
			end
			ST_REDUCE: begin
				mm_req.start        = mm_stat.done;
				mm_req.multiplicand = mex_pkg::ONE_WORD;
				mm_req.multiplier   = mex_pkg::ONE_WORD;
			end
			ST_SQUARE: begin
				if (exp_q[mex_pkg::WORD_BITS-1]) begin
					mm_req.start        = mm_stat.done;
					mm_req.multiplicand = mm_product;
					mm_req.multiplier   = base_q;
				end else begin
					mm_req.start        = mm_stat.done && !last_bit;
					mm_req.multiplicand = mm_product;
					mm_req.multiplier   = mm_product;
				end
			end
			ST_MULT: begin
				mm_req.start        = mm_stat.done && !last_bit;
				mm_req.multiplicand = mm_product;
				mm_req.multiplier   = mm_product;
			end
			ST_FINISH: begin
				mm_req = '0;
			end
			default: begin
				mm_req = '0;
			end
		endcase
	end

	mex_modmul u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mm_req),
		.modulus (modulus_q),
		.stat    (mm_stat),
		.product (mm_product)
	);

	// Sequencer over the exponent bits, modulus register and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			modulus_q  <= mex_pkg::MODULUS_RESET;
			base_q     <= '0;
			exp_q      <= '0;
			res_q      <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				modulus_q <= cfg_data;
			end
			// A result leaving while the next one is loaded keeps valid high.
			if (m_tvalid_q && m_tready && state_q != ST_FINISH) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						exp_q <= s_tdata[63:32];
						cnt_q <= mex_pkg::LAST_BIT;
						if (small_mod) begin
							res_q   <= '0;
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_REDUCE;
						end
					end
				end
				ST_REDUCE: begin
					if (mm_stat.done) begin
						base_q  <= mm_product;
						state_q <= ST_SQUARE;
					end
				end
				ST_SQUARE: begin
					if (mm_stat.done) begin
						res_q <= mm_product;
						if (exp_q[mex_pkg::WORD_BITS-1]) begin
							state_q <= ST_MULT;
						end else if (last_bit) begin
							state_q <= ST_FINISH;
						end else begin
							cnt_q <= cnt_q - 1'b1;
							exp_q <= {exp_q[mex_pkg::WORD_BITS-2:0], 1'b0};
						end
					end
				end
				ST_MULT: begin
					if (mm_stat.done) begin
						res_q <= mm_product;
						if (last_bit) begin
							state_q <= ST_FINISH;
						end else begin
							cnt_q   <= cnt_q - 1'b1;
							exp_q   <= {exp_q[mex_pkg::WORD_BITS-2:0], 1'b0};
							state_q <= ST_SQUARE;
						end
					end
				end
				ST_FINISH: begin
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q  <= res_q;
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`MEX_ASSERT(a_done_in_work, mm_stat.done |-> state_q == ST_REDUCE || state_q == ST_SQUARE || state_q == ST_MULT, "multiplier finished outside a work state")
	`MEX_ASSERT(a_idle_quiet, state_q == ST_IDLE || state_q == ST_FINISH |-> !mm_stat.busy, "multiplier busy while sequencer is not working")
	`MEX_ASSERT(a_result_range, m_tvalid_q && !small_mod |-> m_tdata_q < modulus_q, "result not reduced below modulus")
	`MEX_ASSERT(a_small_mod_zero, m_tvalid_q && small_mod |-> m_tdata_q == '0, "nonzero result for modulus below two")

endmodule

[tb/sv/modular_exponentiation_core_checker.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation checker
// Watches the configuration, request and result channels of the core. It
// keeps its own copy of the modulus and predicts base ^ exponent mod modulus
// for every accepted request. It compares each accepted result in order with
// the oldest prediction and hands the failure count and the number of
// outstanding results to the testbench top.
// ----------------------------------------------------------------------------
module modular_exponentiation_core_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// tdata: base_value [31:0], exponent [63:32].
	input  logic [63:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// tdata: power_result [31:0].
	input  logic [31:0] m_tdata,
	output int          fail_count,
	output int          pending
);

	// One outstanding request together with the power it must produce.
	typedef struct {
		mex_pkg::word_t base_value;
		mex_pkg::word_t exponent;
		mex_pkg::word_t modulus;
		mex_pkg::word_t power_result;
	} power_request_t;

	power_request_t expected_powers [$];
	mex_pkg::word_t modulus_copy;
	int             mismatches = 0;

	assign fail_count = mismatches;

	// Left-to-right square and multiply. Every product is taken in 64 bits and
	// reduced at once, which gives the same residue as the bit-serial datapath.
	function automatic mex_pkg::word_t predict_power(input mex_pkg::word_t base_in,
			input mex_pkg::word_t exp_in, input mex_pkg::word_t n);
		logic [63:0] acc;
		logic [63:0] reduced_base;
		if (n < 2) begin
			return '0;
		end
		reduced_base = 64'(base_in) % 64'(n);
		acc = 64'd1;
		for (int i = mex_pkg::WORD_BITS - 1; i >= 0; i--) begin
			acc = (acc * acc) % 64'(n);
			if (exp_in[i]) begin
				acc = (acc * reduced_base) % 64'(n);
			end
		end
		return mex_pkg::word_t'(acc);
	endfunction

	task automatic report_failure(input string msg);
		mismatches++;
		$display("ERROR at %0t: %s", $realtime, msg);
	endtask

	// Track the modulus, predict on each accepted request, compare each result.
	always @(posedge clk or negedge arst_n) begin : watch_channels
		power_request_t req;
		if (!arst_n) begin
			modulus_copy = mex_pkg::MODULUS_RESET;
			expected_powers.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				modulus_copy = cfg_data;
			end
			if (m_tvalid && m_tready) begin
				if (expected_powers.size() == 0) begin
					report_failure($sformatf("result %h with no request outstanding",
						m_tdata));
				end else begin
					req = expected_powers.pop_front();
					if (m_tdata !== req.power_result) begin
						report_failure($sformatf(
							"power_result %h, expected %h (base %h exp %h mod %h)",
							m_tdata, req.power_result, req.base_value, req.exponent,
							req.modulus));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				req.base_value   = s_tdata[31:0];
				req.exponent     = s_tdata[63:32];
				req.modulus      = modulus_copy;
				req.power_result = predict_power(req.base_value, req.exponent,
					modulus_copy);
				expected_powers.push_back(req);
			end
			pending <= expected_powers.size();
		end
	end

endmodule

[tb/sv/modular_exponentiation_core_tb.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Drives the core with a directed set of boundary requests and then random
// requests under a series of modulus settings, including modulus zero, one,
// two and the largest word. Sender gaps and receiver stalls vary by phase.
// A checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module modular_exponentiation_core_tb;

	localparam int CYCLE_LIMIT   = 3000000;
	localparam int RANDOM_PHASES = 13;
	localparam int PHASE_ITEMS   = 21;
	localparam int DRAIN_CYCLES  = 64;

	// Moduli visited in every third random phase.
	localparam mex_pkg::word_t BOUNDARY_MODULI [5] = '{
		32'hFFFF_FFFF, 32'h0000_0002, 32'h0000_0001, 32'h8000_0000, 32'h0000_0000
	};

	// Handshake pacing of one phase.
	typedef enum int {
		PACE_FULL,
		PACE_SENDER_IDLE,
		PACE_RECEIVER_STALL,
		PACE_BOTH
	} pace_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;

	int fail_count;
	int pending;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	modular_exponentiation_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	modular_exponentiation_core_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("modular_exponentiation_core_tb NOT OK");
			$finish;
		end
	end

	// Result receiver with random stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic set_pace(input pace_t pace);
		case (pace)
			PACE_FULL: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			PACE_SENDER_IDLE: begin
				send_idle_pct = 57;
				recv_stall_pct = 0;
			end
			PACE_RECEIVER_STALL: begin
				send_idle_pct = 0;
				recv_stall_pct = 57;
			end
			default: begin
				send_idle_pct = 19;
				recv_stall_pct = 19;
			end
		endcase
	endtask

	// Sends one request; returns at the edge where it is accepted.
	task automatic send_request(input mex_pkg::word_t base_value,
			input mex_pkg::word_t exponent);
		if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {exponent, base_value};
		do @(posedge clk); while (!s_tready);
	endtask

	// Lowers the request valid and waits until every result has come back.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Writes the modulus once the core is idle.
	task automatic set_modulus(input mex_pkg::word_t value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		mex_pkg::word_t n;
		mex_pkg::word_t b;
		mex_pkg::word_t e;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. First the modulus left at its reset value of two.
		set_pace(PACE_FULL);
		send_request(32'h0000_0000, 32'h0000_0000);
		send_request(32'h0000_0001, 32'h0000_0000);
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(32'h0000_0003, 32'h0000_0001);

		// Largest modulus: exponent zero, bases that reduce to zero, full words.
		set_modulus(32'hFFFF_FFFF);
		send_request(32'h0000_0000, 32'h0000_0000);
		send_request(32'hFFFF_FFFF, 32'h0000_0000);
		send_request(32'h0000_0000, 32'h0000_0005);
		send_request(32'hFFFF_FFFF, 32'h0000_0001);
		send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
		send_request(32'h0000_0002, 32'h0000_001F);
		send_request(32'h0000_0002, 32'h0000_0020);
		send_request(32'h0001_2345, 32'h8000_0000);

		// Modulus zero and one answer zero whatever the request.
		set_modulus(32'h0000_0000);
		send_request(32'h0000_0005, 32'h0000_0003);
		send_request(32'h0000_0000, 32'h0000_0000);
		set_modulus(32'h0000_0001);
		send_request(32'h0000_0007, 32'h0000_0007);
		send_request(32'hFFFF_FFFF, 32'h0000_0000);

		// A prime modulus: Fermat's little theorem and a base equal to it.
		set_modulus(32'hFFFF_FFFB);
		send_request(32'hFFFF_FFFA, 32'hFFFF_FFFA);
		send_request(32'hFFFF_FFFB, 32'h1234_5678);
		send_request(32'h0000_0003, 32'hFFFF_FFFA);

		// Power of two modulus, where many partial products vanish.
		set_modulus(32'h8000_0000);
		send_request(32'h0000_0003, 32'h7FFF_FFFF);
		send_request(32'h0000_0002, 32'h0000_0040);

		// Random part: one modulus and one pacing per phase.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p % 3)
				0: n = BOUNDARY_MODULI[(p / 3) % 5];
				1: n = mex_pkg::word_t'($urandom_range(2, 60));
				default: n = $urandom();
			endcase
			set_modulus(n);
			set_pace(pace_t'(p % 4));
			repeat (PHASE_ITEMS) begin
				b = $urandom();
				e = $urandom();
				case ($urandom_range(0, 9))
					5: e = mex_pkg::word_t'($urandom_range(0, 40));
					6: e = ($urandom_range(0, 1) != 0) ? '0 : '1;
					7: b = n * mex_pkg::word_t'($urandom_range(0, 5)) -
						mex_pkg::word_t'($urandom_range(0, 1));
					8: b = mex_pkg::word_t'($urandom_range(0, 3));
					9: e = mex_pkg::ONE_WORD << $urandom_range(0, mex_pkg::WORD_BITS - 1);
					default: ;
				endcase
				send_request(b, e);
			end
		end

		// Drain and verdict.
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("modular_exponentiation_core_tb OK");
		end else begin
			$display("modular_exponentiation_core_tb NOT OK");
		end
		$finish;
	end

endmodule

[modular_exponentiation_core.f]
+incdir+rtl/core
rtl/core/mex_pkg.sv
rtl/core/mex_modmul.sv
rtl/core/modular_exponentiation_core.sv
tb/sv/modular_exponentiation_core_checker.sv
tb/sv/modular_exponentiation_core_tb.sv
